// File: src/mer_pkg.sv
// Shared types and constants of the midpoint ellipse rasteriser.
package mer_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int RADIUS_BITS_DEF = 10;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef enum logic [3:0] {
        MS_NONE,
        MS_AA,
        MS_BB,
        MS_A2Y,
        MS_B2X1,
        MS_A2Y1,
        MS_B2X3,
        MS_A2Y2,
        MS_A2Y3,
        MS_XSQ,
        MS_YSQ,
        MS_B2P,
        MS_A2P,
        MS_A2B2
    } t_mul_sel;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_START,
        ACC_ADD_P4,
        ACC_SUB_P4,
        ACC_ADD_P,
        ACC_LOAD_P
    } t_acc_op;

    typedef struct packed {
        logic      load_start;
        t_mul_sel  mul_sel;
        t_acc_op   acc_op;
        logic      lhs_load;
        logic      a2_load;
        logic      b2_load;
        logic      x_inc;
        logic      y_dec;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic lt;
        logic d_neg;
        logic y_zero;
        logic out_free;
    } t_stat;

endpackage

// File: src/mer_dp.sv
// Datapath: held operands, shared multiplier, decision accumulator and result register.
module mer_dp
    import mer_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd_bus,
    output t_stat                         o_stat,
    input  logic signed [COORD_BITS-1:0]  i_center_x,
    input  logic signed [COORD_BITS-1:0]  i_center_y,
    input  logic        [RADIUS_BITS-1:0] i_radius_x,
    input  logic        [RADIUS_BITS-1:0] i_radius_y,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_data,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic signed [COORD_BITS:0]    o_right_x,
    output logic signed [COORD_BITS:0]    o_left_x,
    output logic signed [COORD_BITS:0]    o_lower_y,
    output logic signed [COORD_BITS:0]    o_upper_y,
    output logic                          o_fill_rows,
    output logic                          o_last
);

    localparam int WA  = 2 * RADIUS_BITS + 1;
    localparam int WB  = 2 * RADIUS_BITS + 6;
    localparam int WP  = WA + WB;
    localparam int WD  = 4 * RADIUS_BITS + 8;
    localparam int WX  = RADIUS_BITS + 1;
    localparam int WQ  = 2 * RADIUS_BITS;
    localparam int OUT = COORD_BITS + 1;
    localparam int WS  = ((COORD_BITS > WX + 1) ? COORD_BITS : WX + 1) + 1;

    logic signed [COORD_BITS-1:0]  r_cx;
    logic signed [COORD_BITS-1:0]  r_cy;
    logic        [RADIUS_BITS-1:0] r_ra;
    logic        [WQ-1:0]          r_a2;
    logic        [WQ-1:0]          r_b2;
    logic        [WX-1:0]          r_x;
    logic        [RADIUS_BITS-1:0] r_y;
    logic signed [WP-1:0]          r_prod;
    logic signed [WP-1:0]          r_lhs;
    logic signed [WD-1:0]          r_d;
    logic signed [WD-1:0]          n_d;
    logic                          r_fill;
    logic                          r_out_valid;

    logic signed [WB-1:0] x_e, y_e, x2p1, x2p2, x2p3, y2m1, y2m2, two_m_2y, three_m_2y;
    logic signed [WA-1:0] a2_a, b2_a, ra_a, y_a, x2p1_a, y2m2_a;
    logic signed [WA-1:0] op_a;
    logic signed [WB-1:0] op_b;
    logic signed [WP-1:0] prod;
    logic signed [WD-1:0] p1, p4, a2_d;
    logic signed [WS-1:0] cx_s, cy_s, x_s, y_s;
    logic signed [WS-1:0] right_s, left_s, lower_s, upper_s;

    assign x_e        = signed'(WB'(r_x));
    assign y_e        = signed'(WB'(r_y));
    assign x2p1       = x_e + x_e + WB'(1);
    assign x2p2       = x_e + x_e + WB'(2);
    assign x2p3       = x_e + x_e + WB'(3);
    assign y2m1       = y_e + y_e - WB'(1);
    assign y2m2       = y_e + y_e - WB'(2);
    assign two_m_2y   = WB'(2) - y_e - y_e;
    assign three_m_2y = WB'(3) - y_e - y_e;

    assign a2_a   = signed'(WA'(r_a2));
    assign b2_a   = signed'(WA'(r_b2));
    assign ra_a   = signed'(WA'(r_ra));
    assign y_a    = signed'(WA'(r_y));
    assign x2p1_a = WA'(x2p1);
    assign y2m2_a = WA'(y2m2);

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (i_cmd_bus.mul_sel)
            MS_AA: begin
                op_a = ra_a;
                op_b = WB'(ra_a);
            end
            MS_BB: begin
                op_a = y_a;
                op_b = y_e;
            end
            MS_A2Y: begin
                op_a = a2_a;
                op_b = y_e;
            end
            MS_B2X1: begin
                op_a = b2_a;
                op_b = x2p2;
            end
            MS_A2Y1: begin
                op_a = a2_a;
                op_b = y2m1;
            end
            MS_B2X3: begin
                op_a = b2_a;
                op_b = x2p3;
            end
            MS_A2Y2: begin
                op_a = a2_a;
                op_b = two_m_2y;
            end
            MS_A2Y3: begin
                op_a = a2_a;
                op_b = three_m_2y;
            end
            MS_XSQ: begin
                op_a = x2p1_a;
                op_b = x2p1;
            end
            MS_YSQ: begin
                op_a = y2m2_a;
                op_b = y2m2;
            end
            MS_B2P: begin
                op_a = b2_a;
                op_b = WB'(r_prod);
            end
            MS_A2P: begin
                op_a = a2_a;
                op_b = WB'(r_prod);
            end
            MS_A2B2: begin
                op_a = a2_a;
                op_b = WB'(b2_a);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod = op_a * op_b;

    assign p1   = WD'(r_prod);
    assign p4   = p1 <<< 2;
    assign a2_d = signed'(WD'(r_a2));

    always_comb begin
        case (i_cmd_bus.acc_op)
            ACC_START:  n_d = p4 + a2_d;
            ACC_ADD_P4: n_d = r_d + p4;
            ACC_SUB_P4: n_d = r_d - p4;
            ACC_ADD_P:  n_d = r_d + p1;
            ACC_LOAD_P: n_d = p1;
            default:    n_d = r_d;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.mul_sel != MS_NONE) begin
            r_prod <= prod;
        end
        r_d <= n_d;
        if (i_cmd_bus.lhs_load) begin
            r_lhs <= r_prod;
        end
        if (i_cmd_bus.a2_load) begin
            r_a2 <= r_prod[WQ-1:0];
        end
        if (i_cmd_bus.b2_load) begin
            r_b2 <= r_prod[WQ-1:0];
        end
        if (i_cmd_bus.load_start) begin
            r_cx <= i_center_x;
            r_cy <= i_center_y;
            r_ra <= i_radius_x;
            r_x  <= '0;
            r_y  <= i_radius_y;
        end else begin
            if (i_cmd_bus.x_inc) begin
                r_x <= r_x + WX'(1);
            end
            if (i_cmd_bus.y_dec) begin
                r_y <= r_y - RADIUS_BITS'(1);
            end
        end
    end

    assign cx_s    = WS'(r_cx);
    assign cy_s    = WS'(r_cy);
    assign x_s     = signed'(WS'(r_x));
    assign y_s     = signed'(WS'(r_y));
    assign right_s = cx_s + x_s;
    assign left_s  = cx_s - x_s;
    assign lower_s = cy_s + y_s;
    assign upper_s = cy_s - y_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fill <= i_cfg_data;
            end
            if (i_cmd_bus.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.out_load) begin
            o_right_x   <= right_s[OUT-1:0];
            o_left_x    <= left_s[OUT-1:0];
            o_lower_y   <= lower_s[OUT-1:0];
            o_upper_y   <= upper_s[OUT-1:0];
            o_fill_rows <= r_fill;
            o_last      <= (r_y == '0);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.lt       = (r_lhs < r_prod);
    assign o_stat.d_neg    = r_d[WD-1];
    assign o_stat.y_zero   = (r_y == '0);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

endmodule

// File: src/mer_ctrl.sv
// Controller: sequences the shared multiplier and accumulator for each beat.
module mer_ctrl
    import mer_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_cmd,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd_bus
);

    typedef enum logic [20:0] {
        ST_IDLE    = 21'd1 << 0,
        ST_S_AA    = 21'd1 << 1,
        ST_S_BB    = 21'd1 << 2,
        ST_S_A2B   = 21'd1 << 3,
        ST_S_INIT  = 21'd1 << 4,
        ST_R1_LHS  = 21'd1 << 5,
        ST_R1_RHS  = 21'd1 << 6,
        ST_R1_CMP  = 21'd1 << 7,
        ST_R1_ADD  = 21'd1 << 8,
        ST_R1_ADDB = 21'd1 << 9,
        ST_R1_ADDA = 21'd1 << 10,
        ST_R2_BX   = 21'd1 << 11,
        ST_R2_YSQ  = 21'd1 << 12,
        ST_R2_AY   = 21'd1 << 13,
        ST_R2_AB   = 21'd1 << 14,
        ST_R2_INIT = 21'd1 << 15,
        ST_R2_STEP = 21'd1 << 16,
        ST_R2_POS  = 21'd1 << 17,
        ST_R2_NEGA = 21'd1 << 18,
        ST_R2_NEGB = 21'd1 << 19,
        ST_EMIT    = 21'd1 << 20
    } t_state;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_R1   = 3'b010,
        PH_R2   = 3'b100
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   in_acc;

    assign in_acc     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        o_cmd_bus = '{load_start: 1'b0, mul_sel: MS_NONE, acc_op: ACC_HOLD,
                      lhs_load: 1'b0, a2_load: 1'b0, b2_load: 1'b0,
                      x_inc: 1'b0, y_dec: 1'b0, out_load: 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_cmd == CMD_START) begin
                        o_cmd_bus.load_start = 1'b1;
                        n_state = ST_S_AA;
                    end else if (r_phase == PH_R1) begin
                        n_state = ST_R1_LHS;
                    end else if (r_phase == PH_R2) begin
                        n_state = ST_R2_STEP;
                    end
                end
            end
            ST_S_AA: begin
                o_cmd_bus.mul_sel = MS_AA;
                n_state = ST_S_BB;
            end
            ST_S_BB: begin
                o_cmd_bus.a2_load = 1'b1;
                o_cmd_bus.mul_sel = MS_BB;
                n_state = ST_S_A2B;
            end
            ST_S_A2B: begin
                o_cmd_bus.b2_load = 1'b1;
                o_cmd_bus.acc_op  = ACC_START;
                o_cmd_bus.mul_sel = MS_A2Y;
                n_state = ST_S_INIT;
            end
            ST_S_INIT: begin
                o_cmd_bus.acc_op = ACC_SUB_P4;
                n_phase = PH_R1;
                n_state = ST_EMIT;
            end
            ST_R1_LHS: begin
                o_cmd_bus.mul_sel = MS_B2X1;
                n_state = ST_R1_RHS;
            end
            ST_R1_RHS: begin
                o_cmd_bus.lhs_load = 1'b1;
                o_cmd_bus.mul_sel  = MS_A2Y1;
                n_state = ST_R1_CMP;
            end
            ST_R1_CMP: begin
                if (i_stat.lt) begin
                    o_cmd_bus.mul_sel = MS_B2X3;
                    n_state = i_stat.d_neg ? ST_R1_ADD : ST_R1_ADDB;
                end else begin
                    o_cmd_bus.mul_sel = MS_XSQ;
                    n_phase = PH_R2;
                    n_state = ST_R2_BX;
                end
            end
            ST_R1_ADD: begin
                o_cmd_bus.acc_op = ACC_ADD_P4;
                o_cmd_bus.x_inc  = 1'b1;
                n_state = ST_EMIT;
            end
            ST_R1_ADDB: begin
                o_cmd_bus.acc_op  = ACC_ADD_P4;
                o_cmd_bus.mul_sel = MS_A2Y2;
                n_state = ST_R1_ADDA;
            end
            ST_R1_ADDA: begin
                o_cmd_bus.acc_op = ACC_ADD_P4;
                o_cmd_bus.x_inc  = 1'b1;
                o_cmd_bus.y_dec  = 1'b1;
                n_state = ST_EMIT;
            end
            ST_R2_BX: begin
                o_cmd_bus.mul_sel = MS_B2P;
                n_state = ST_R2_YSQ;
            end
            ST_R2_YSQ: begin
                o_cmd_bus.acc_op  = ACC_LOAD_P;
                o_cmd_bus.mul_sel = MS_YSQ;
                n_state = ST_R2_AY;
            end
            ST_R2_AY: begin
                o_cmd_bus.mul_sel = MS_A2P;
                n_state = ST_R2_AB;
            end
            ST_R2_AB: begin
                o_cmd_bus.acc_op  = ACC_ADD_P;
                o_cmd_bus.mul_sel = MS_A2B2;
                n_state = ST_R2_INIT;
            end
            ST_R2_INIT: begin
                o_cmd_bus.acc_op = ACC_SUB_P4;
                n_state = ST_R2_STEP;
            end
            ST_R2_STEP: begin
                if (i_stat.y_zero) begin
                    n_phase = PH_IDLE;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd_bus.mul_sel = MS_A2Y3;
                    n_state = i_stat.d_neg ? ST_R2_NEGA : ST_R2_POS;
                end
            end
            ST_R2_POS: begin
                o_cmd_bus.acc_op = ACC_ADD_P4;
                o_cmd_bus.y_dec  = 1'b1;
                n_state = ST_EMIT;
            end
            ST_R2_NEGA: begin
                o_cmd_bus.acc_op  = ACC_ADD_P4;
                o_cmd_bus.mul_sel = MS_B2X1;
                n_state = ST_R2_NEGB;
            end
            ST_R2_NEGB: begin
                o_cmd_bus.acc_op = ACC_ADD_P4;
                o_cmd_bus.x_inc  = 1'b1;
                o_cmd_bus.y_dec  = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd_bus.out_load = 1'b1;
                    if (i_stat.y_zero) begin
                        n_phase = PH_IDLE;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_IDLE;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

endmodule

// File: src/midpoint_ellipse_rasterizer.sv
// Top level of the midpoint ellipse rasteriser: controller, datapath and checks.
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------------------
//   in      | i_in_valid, o_in_stall | i_cmd, i_center_x/y, i_radius_x/y
//   out     | o_out_valid, i_out_stall | o_right_x, o_left_x, o_lower_y, o_upper_y,
//           |                        | o_fill_rows, o_last
//   cfg     | i_cfg_we               | i_cfg_data (fill enable)
//
// A start beat, a region-one step, a region-two step and the step that crosses into
// region two each run as a sequence of controller states while the in channel stalls;
// one shared multiplier with a registered product, used once per cycle, sets the order.
// Reset is synchronous and active low; it clears the controller, phase, fill enable
// and result valid.
// A finished result waits in the output register; the next in beat is taken meanwhile.
module midpoint_ellipse_rasterizer
    import mer_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd,
    input  logic signed [COORD_BITS-1:0]  i_center_x,
    input  logic signed [COORD_BITS-1:0]  i_center_y,
    input  logic        [RADIUS_BITS-1:0] i_radius_x,
    input  logic        [RADIUS_BITS-1:0] i_radius_y,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [COORD_BITS:0]    o_right_x,
    output logic signed [COORD_BITS:0]    o_left_x,
    output logic signed [COORD_BITS:0]    o_lower_y,
    output logic signed [COORD_BITS:0]    o_upper_y,
    output logic                          o_fill_rows,
    output logic                          o_last
);

    t_cmd  cmd_bus;
    t_stat stat;

    mer_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd_bus  (cmd_bus)
    );

    mer_dp #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_bus   (cmd_bus),
        .o_stat      (stat),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_radius_x  (i_radius_x),
        .i_radius_y  (i_radius_y),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_right_x   (o_right_x),
        .o_left_x    (o_left_x),
        .o_lower_y   (o_lower_y),
        .o_upper_y   (o_upper_y),
        .o_fill_rows (o_fill_rows),
        .o_last      (o_last)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_bus.out_load |-> stat.out_free)
        else $error("result register loaded while a result still waits");

    a_start_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_bus.load_start |-> (i_in_valid && !o_in_stall && i_cmd == CMD_START))
        else $error("start operands latched without an accepted start beat");

    a_last_on_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_lower_y == o_upper_y))
        else $error("last point set has a non-zero y offset");

endmodule

// File: tb/ellipse_point_checker.sv
// Checker for the ellipse rasteriser: tracks the pen, predicts point sets and compares beats.
`timescale 1ns / 1ps

module ellipse_point_checker
    import mer_pkg::*;
(
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic                              i_cmd,
    input  logic signed [COORD_BITS_DEF-1:0]  i_center_x,
    input  logic signed [COORD_BITS_DEF-1:0]  i_center_y,
    input  logic        [RADIUS_BITS_DEF-1:0] i_radius_x,
    input  logic        [RADIUS_BITS_DEF-1:0] i_radius_y,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_data,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [COORD_BITS_DEF:0]    i_right_x,
    input  logic signed [COORD_BITS_DEF:0]    i_left_x,
    input  logic signed [COORD_BITS_DEF:0]    i_lower_y,
    input  logic signed [COORD_BITS_DEF:0]    i_upper_y,
    input  logic                              i_fill_rows,
    input  logic                              i_last,
    output int                                o_errors,
    output int                                o_pending
);

    localparam int PW = COORD_BITS_DEF + 1;

    typedef enum logic [1:0] {
        PEN_IDLE,
        PEN_REGION1,
        PEN_REGION2
    } t_pen_phase;

    typedef struct packed {
        logic signed [PW-1:0] right_x;
        logic signed [PW-1:0] left_x;
        logic signed [PW-1:0] lower_y;
        logic signed [PW-1:0] upper_y;
        logic                 fill_rows;
        logic                 last;
    } t_point_set;

    t_point_set point_q[$];
    t_pen_phase pen_phase = PEN_IDLE;
    logic       fill_en   = 1'b0;
    longint     pen_x, pen_y, pen_d, ctr_x, ctr_y, rx_sq, ry_sq;
    int         err_cnt   = 0;

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        err_cnt++;
    endtask

    task automatic check_field(input string what, input longint want,
                               input longint got);
        if (want != got)
            report_mismatch(what, want, got);
    endtask

    function automatic void emit_points();
        t_point_set p;
        p.right_x   = PW'(ctr_x + pen_x);
        p.left_x    = PW'(ctr_x - pen_x);
        p.lower_y   = PW'(ctr_y + pen_y);
        p.upper_y   = PW'(ctr_y - pen_y);
        p.fill_rows = fill_en;
        p.last      = (pen_y == 0);
        if (pen_y == 0)
            pen_phase = PEN_IDLE;
        point_q.push_back(p);
    endfunction

    function automatic void advance_pen(input logic cmd,
                                        input logic signed [COORD_BITS_DEF-1:0] cx,
                                        input logic signed [COORD_BITS_DEF-1:0] cy,
                                        input logic [RADIUS_BITS_DEF-1:0] rx,
                                        input logic [RADIUS_BITS_DEF-1:0] ry);
        longint a;
        longint b;
        if (cmd == CMD_START) begin
            a         = rx;
            b         = ry;
            ctr_x     = cx;
            ctr_y     = cy;
            rx_sq     = a * a;
            ry_sq     = b * b;
            pen_x     = 0;
            pen_y     = b;
            pen_d     = 4 * ry_sq - 4 * rx_sq * b + rx_sq;
            pen_phase = PEN_REGION1;
            emit_points();
            return;
        end
        if (pen_phase == PEN_REGION1) begin
            if (ry_sq * 2 * (pen_x + 1) < rx_sq * (2 * pen_y - 1)) begin
                if (pen_d < 0) begin
                    pen_d += 4 * (ry_sq * (2 * pen_x + 3));
                end else begin
                    pen_d += 4 * (ry_sq * (2 * pen_x + 3) + rx_sq * (2 - 2 * pen_y));
                    pen_y -= 1;
                end
                pen_x += 1;
                emit_points();
                return;
            end
            pen_d = ry_sq * (4 * pen_x * pen_x + 4 * pen_x + 1)
                  + rx_sq * (4 * pen_y * pen_y - 8 * pen_y + 4)
                  - 4 * rx_sq * ry_sq;
            pen_phase = PEN_REGION2;
        end
        if (pen_phase == PEN_REGION2) begin
            if (pen_y <= 0) begin
                pen_phase = PEN_IDLE;
                return;
            end
            if (pen_d < 0) begin
                pen_d += 4 * (ry_sq * 2 * (pen_x + 1) + rx_sq * (3 - 2 * pen_y));
                pen_x += 1;
            end else begin
                pen_d += 4 * (rx_sq * (3 - 2 * pen_y));
            end
            pen_y -= 1;
            emit_points();
        end
    endfunction

    always @(posedge i_clk) begin
        t_point_set want;
        if (!i_rst_n) begin
            point_q.delete();
            pen_phase = PEN_IDLE;
            fill_en   = 1'b0;
            pen_x     = 0;
            pen_y     = 0;
            pen_d     = 0;
            ctr_x     = 0;
            ctr_y     = 0;
            rx_sq     = 0;
            ry_sq     = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (point_q.size() == 0) begin
                    report_mismatch("unexpected point set (left_x)", 0, i_left_x);
                end else begin
                    want = point_q.pop_front();
                    check_field("right_x", want.right_x, i_right_x);
                    check_field("left_x", want.left_x, i_left_x);
                    check_field("lower_y", want.lower_y, i_lower_y);
                    check_field("upper_y", want.upper_y, i_upper_y);
                    check_field("fill_rows", want.fill_rows, i_fill_rows);
                    check_field("last", want.last, i_last);
                end
            end
            if (i_cfg_we)
                fill_en = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                advance_pen(i_cmd, i_center_x, i_center_y, i_radius_x, i_radius_y);
        end
        o_errors  <= err_cnt;
        o_pending <= point_q.size();
    end

endmodule

// File: tb/midpoint_ellipse_rasterizer_tb.sv
// Testbench top for the ellipse rasteriser: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_tb;
    import mer_pkg::*;

    localparam int CB     = COORD_BITS_DEF;
    localparam int RB     = RADIUS_BITS_DEF;
    localparam int SETTLE = 40;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 i_cmd       = CMD_START;
    logic signed [CB-1:0] i_center_x  = '0;
    logic signed [CB-1:0] i_center_y  = '0;
    logic        [RB-1:0] i_radius_x  = '0;
    logic        [RB-1:0] i_radius_y  = '0;
    logic                 i_cfg_we    = 1'b0;
    logic                 i_cfg_data  = 1'b0;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic signed [CB:0]   o_right_x;
    logic signed [CB:0]   o_left_x;
    logic signed [CB:0]   o_lower_y;
    logic signed [CB:0]   o_upper_y;
    logic                 o_fill_rows;
    logic                 o_last;

    int errors;
    int pending;
    int gap_pct   = 0;
    int stall_pct = 0;

    midpoint_ellipse_rasterizer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_radius_x  (i_radius_x),
        .i_radius_y  (i_radius_y),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_right_x   (o_right_x),
        .o_left_x    (o_left_x),
        .o_lower_y   (o_lower_y),
        .o_upper_y   (o_upper_y),
        .o_fill_rows (o_fill_rows),
        .o_last      (o_last)
    );

    ellipse_point_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_radius_x  (i_radius_x),
        .i_radius_y  (i_radius_y),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_right_x   (o_right_x),
        .i_left_x    (o_left_x),
        .i_lower_y   (o_lower_y),
        .i_upper_y   (o_upper_y),
        .i_fill_rows (o_fill_rows),
        .i_last      (o_last),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_beat(input logic cmd, input logic signed [CB-1:0] cx,
                             input logic signed [CB-1:0] cy, input logic [RB-1:0] rx,
                             input logic [RB-1:0] ry);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_center_x <= cx;
        i_center_y <= cy;
        i_radius_x <= rx;
        i_radius_y <= ry;
        do
            @(posedge i_clk);
        while (o_in_stall);
    endtask

    task automatic draw_ellipse(input logic signed [CB-1:0] cx, input logic signed [CB-1:0] cy,
                                input logic [RB-1:0] a, input logic [RB-1:0] b,
                                input int n_steps);
        send_beat(CMD_START, cx, cy, a, b);
        repeat (n_steps)
            send_beat(CMD_STEP, CB'($urandom), CB'($urandom), RB'($urandom), RB'($urandom));
    endtask

    task automatic drain_and_set_fill(input logic fill);
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= fill;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_random(input int gap, input int stall, input int target,
                              input logic fill);
        int sent;
        int kind;
        int a;
        int b;
        int span;
        int n_steps;
        logic cmd;
        sent = 0;
        drain_and_set_fill(fill);
        gap_pct   = gap;
        stall_pct = stall;
        while (sent < target) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                span    = ($urandom_range(3) == 0) ? 40 : 12;
                a       = $urandom_range(span);
                b       = $urandom_range(span);
                n_steps = a + b + $urandom_range(2);
                draw_ellipse(CB'($urandom), CB'($urandom), RB'(a), RB'(b), n_steps);
                sent += 1 + n_steps;
            end else if (kind < 85) begin
                a = $urandom_range(20);
                draw_ellipse(CB'($urandom), CB'($urandom), RB'($urandom), RB'($urandom), a);
                sent += 1 + a;
            end else begin
                cmd = 1'($urandom_range(1));
                send_beat(cmd, CB'($urandom), CB'($urandom), RB'($urandom), RB'($urandom));
                sent += 1;
            end
        end
    endtask

    initial begin
        #(10_000_000);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(CMD_STEP, '0, '0, '0, '0);
        draw_ellipse(CB'(-2048), CB'(2047), '0, '0, 1);
        draw_ellipse(CB'(2047), CB'(-2048), '0, RB'(3), 4);
        draw_ellipse(CB'(-1), CB'(1), RB'(5), RB'(1), 6);
        draw_ellipse(CB'(2047), CB'(2047), RB'(1023), RB'(1023), 3);
        draw_ellipse(CB'(-2048), CB'(-2048), RB'(2), RB'(3), 6);

        run_random(33, 55, 240, 1'b1);
        run_random(55, 33, 240, 1'b0);
        run_random(0, 0, 240, 1'b1);

        i_in_valid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: midpoint_ellipse_rasterizer.f
src/mer_pkg.sv
src/mer_dp.sv
src/mer_ctrl.sv
src/midpoint_ellipse_rasterizer.sv
tb/ellipse_point_checker.sv
tb/midpoint_ellipse_rasterizer_tb.sv
